[rtl/core/aabb_sphere_classify_assert.svh]
// Assertion helpers for the RTL.
`ifndef AABB_SPHERE_CLASSIFY_ASSERT_SVH
`define AABB_SPHERE_CLASSIFY_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ABC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ABC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/abc_pkg.sv]
package abc_pkg;

   // default coordinate width (signed Q16.16)
   localparam int COORD_BITS_DEF = 32;

   // relation codes
   localparam logic [1:0] REL_OUTSIDE    = 2'd0;
   localparam logic [1:0] REL_INTERSECTS = 2'd1;
   localparam logic [1:0] REL_INSIDE     = 2'd2;

   // stage enables into the squarer
   typedef struct packed {
      logic pp;   // partial product stage
      logic sq;   // recombine stage
   } sq_en_type;

endpackage

[rtl/core/abc_square.sv]
// Two-stage squarer: split operand, square the halves, recombine.
module abc_square #(
   parameter int W = abc_pkg::COORD_BITS_DEF
) (
   input  logic                clock,
   input  abc_pkg::sq_en_type  en,
   input  logic [W-1:0]        val,
   output logic [2*W-1:0]      sq
);

   localparam int L  = W / 2;       // low part width
   localparam int HW = W - L;       // high part width
   localparam int WW = 2 * W;

   logic [HW-1:0]     a;
   logic [L-1:0]      b;
   logic [2*HW-1:0]   hh_in, hh_ff;
   logic [W-1:0]      hl_in, hl_ff;
   logic [2*L-1:0]    ll_in, ll_ff;
   logic [WW-1:0]     sq_in, sq_ff;

   assign a = val[W-1:L];
   assign b = val[L-1:0];

   assign hh_in = (2 * HW)'(a) * (2 * HW)'(a);
   assign hl_in = W'(a) * W'(b);
   assign ll_in = (2 * L)'(b) * (2 * L)'(b);

   // (a*2^L + b)^2 = a^2*2^2L + 2ab*2^L + b^2
   assign sq_in = (WW'(hh_ff) << (2 * L)) + (WW'(hl_ff) << (L + 1)) + WW'(ll_ff);

   always_ff @(posedge clock) begin
      if (en.pp) begin
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         ll_ff <= ll_in;
      end
      if (en.sq) begin
         sq_ff <= sq_in;
      end
   end

   assign sq = sq_ff;

endmodule

[rtl/core/aabb_sphere_classify.sv]
// Channel | Dir | Handshake            | Word
// req_    | in  | req_valid/req_stall  | box min/max corners, center, radius
// rsp_    | out | rsp_valid/rsp_stall  | relation (outside/intersects/inside)
// csr_    | in  | csr_valid/csr_ready  | fast_mode
//
// Five register stages: face distance, partial products, squares, sum,
// compare. rsp_valid is the compare stage's valid bit; one word per cycle
// sustained while rsp_stall is low, set by the fully pipelined
// squarers.
// Synchronous active-high reset clears valid bits and fast_mode.
// Each stage holds only when it is full and the one after it holds, so
// bubbles collapse and a stall on rsp_ backs up one stage at a time.
`include "aabb_sphere_classify_assert.svh"

module aabb_sphere_classify #(
   parameter int COORD_BITS = abc_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // input words
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_BITS-1:0]  req_box_min_x,
   input  logic signed [COORD_BITS-1:0]  req_box_min_y,
   input  logic signed [COORD_BITS-1:0]  req_box_min_z,
   input  logic signed [COORD_BITS-1:0]  req_box_max_x,
   input  logic signed [COORD_BITS-1:0]  req_box_max_y,
   input  logic signed [COORD_BITS-1:0]  req_box_max_z,
   input  logic signed [COORD_BITS-1:0]  req_center_x,
   input  logic signed [COORD_BITS-1:0]  req_center_y,
   input  logic signed [COORD_BITS-1:0]  req_center_z,
   input  logic        [COORD_BITS-2:0]  req_sphere_radius,
   // result words
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic        [1:0]             rsp_relation,
   // configuration
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_fast_mode
);

   localparam int C  = COORD_BITS;
   localparam int RW = C - 1;          // radius width
   localparam int SW = 2 * C + 2;      // three-term sum width

   // ---------------- control ----------------
   logic fast_mode_ff;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;
   abc_pkg::sq_en_type sq_en;

   // a stage loads when empty or when the next stage loads
   assign en5 = !v5_ff || !rsp_stall;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_stall = !en1;
   assign csr_ready = 1'b1;

   assign sq_en.pp = en2;
   assign sq_en.sq = en3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         fast_mode_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (csr_valid && csr_ready) fast_mode_ff <= csr_fast_mode;
      end
   end

   // ---------------- stage 1: face distance, containment ----------------
   logic signed [C-1:0] mn [3];
   logic signed [C-1:0] mx [3];
   logic signed [C-1:0] ctr [3];
   logic [C-1:0]        mag_in [3];
   logic [C-1:0]        mag_ff [3];
   logic [2:0]          fit;
   logic signed [C:0]   r_ext;
   logic [RW-1:0]       r1_ff;
   logic                cont1_ff, cont2_ff, cont3_ff, cont4_ff;

   assign mn[0]  = req_box_min_x;
   assign mn[1]  = req_box_min_y;
   assign mn[2]  = req_box_min_z;
   assign mx[0]  = req_box_max_x;
   assign mx[1]  = req_box_max_y;
   assign mx[2]  = req_box_max_z;
   assign ctr[0] = req_center_x;
   assign ctr[1] = req_center_y;
   assign ctr[2] = req_center_z;
   assign r_ext  = $signed({2'b00, req_sphere_radius});

   always_comb begin
      logic [C:0] below_d;
      logic [C:0] above_d;
      for (int i = 0; i < 3; i++) begin
         // distances to the nearer face are non-negative and fit C bits
         below_d = {mn[i][C-1], mn[i]} - {ctr[i][C-1], ctr[i]};
         above_d = {ctr[i][C-1], ctr[i]} - {mx[i][C-1], mx[i]};
         if (ctr[i] < mn[i]) begin
            mag_in[i] = below_d[C-1:0];
         end else if (ctr[i] > mx[i]) begin
            mag_in[i] = above_d[C-1:0];
         end else begin
            mag_in[i] = '0;
         end
         // sphere stays within both faces of this slab
         fit[i] = !(((C + 1)'(ctr[i]) - r_ext) < (C + 1)'(mn[i])) &&
                  !(((C + 1)'(ctr[i]) + r_ext) > (C + 1)'(mx[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         for (int i = 0; i < 3; i++) mag_ff[i] <= mag_in[i];
         r1_ff    <= req_sphere_radius;
         cont1_ff <= &fit;
      end
   end

   // ---------------- stages 2-3: squares ----------------
   logic [2*C-1:0]  sq [3];
   logic [2*RW-1:0] r_sq;

   for (genvar g = 0; g < 3; g++) begin : g_axis
      abc_square #(.W(C)) u_sq (
         .clock (clock),
         .en    (sq_en),
         .val   (mag_ff[g]),
         .sq    (sq[g])
      );
   end

   abc_square #(.W(RW)) u_rsq (
      .clock (clock),
      .en    (sq_en),
      .val   (r1_ff),
      .sq    (r_sq)
   );

   always_ff @(posedge clock) begin
      if (en2) cont2_ff <= cont1_ff;
      if (en3) cont3_ff <= cont2_ff;
   end

   // ---------------- stage 4: sum of squares ----------------
   logic [SW-1:0]   sum_in, sum_ff;
   logic [2*RW-1:0] r_sq4_ff;

   assign sum_in = SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);

   always_ff @(posedge clock) begin
      if (en4) begin
         sum_ff   <= sum_in;
         r_sq4_ff <= r_sq;
         cont4_ff <= cont3_ff;
      end
   end

   // ---------------- stage 5: classify ----------------
   logic       outside;
   logic [1:0] rel_in, rel_ff;

   // touching counts as outside
   assign outside = sum_ff >= SW'(r_sq4_ff);

   always_comb begin
      if (outside) begin
         rel_in = abc_pkg::REL_OUTSIDE;
      end else if (fast_mode_ff || cont4_ff) begin
         rel_in = abc_pkg::REL_INSIDE;
      end else begin
         rel_in = abc_pkg::REL_INTERSECTS;
      end
   end

   always_ff @(posedge clock) begin
      if (en5) rel_ff <= rel_in;
   end

   assign rsp_valid    = v5_ff;
   assign rsp_relation = rel_ff;

   // ---------------- checks ----------------
   `ABC_ASSERT_NEXT(a_zero_radius_outside, clock, reset,
      v4_ff && en5 && (r_sq4_ff == '0), rsp_relation == abc_pkg::REL_OUTSIDE,
      "zero radius not classified outside")
   `ABC_ASSERT_NOW(a_fast_no_intersect, clock, reset,
      rsp_valid && fast_mode_ff, rsp_relation != abc_pkg::REL_INTERSECTS,
      "intersects reported in fast mode")
   `ABC_ASSERT_NOW(a_stall_only_full, clock, reset,
      req_stall, v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && rsp_stall,
      "input stalled while pipeline has a bubble")
   `ABC_ASSERT_NEXT(a_hold_on_stall, clock, reset,
      v5_ff && rsp_stall, v5_ff && $stable(rel_ff),
      "result lost under stall")

endmodule
